// File: hdl/sac_pkg.sv
`default_nettype none

package sac_pkg;

    localparam int WAYS         = 4;
    localparam int MAX_SET_BITS = 6;
    localparam int ADDR_BITS    = 48;

    localparam int NSETS  = 1 << MAX_SET_BITS;
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int RCMP_W = $clog2(WAYS + 1);
    localparam int CNT_W  = 32;

    localparam int IN_DATA_W  = ((ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 3 * CNT_W;

    localparam int BLOCK_W = 5;
    localparam int SETB_W  = 3;
    localparam int NWAYS_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

    localparam logic [BLOCK_W-1:0] BLOCK_BITS_RESET = 5'd4;
    localparam logic [SETB_W-1:0]  SET_BITS_RESET   = 3'd4;
    localparam logic [NWAYS_W-1:0] WAYS_USED_RESET  = 3'd1;

    typedef struct packed {
        logic [ADDR_BITS-1:0] tag;
        logic [RANK_W-1:0]    rank;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic             hit;
        logic             eviction;
        logic [WAY_W-1:0] way;
        row_t             row;
    } lookup_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: hdl/sac_ram.sv
`default_nettype none

module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read and a write to the same row in one cycle return the old contents.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/sac_lookup.sv
`default_nettype none

module sac_lookup (
    input  wire sac_pkg::row_t                   row,
    input  wire logic [sac_pkg::WAYS-1:0]        valid,
    input  wire logic [sac_pkg::ADDR_BITS-1:0]   tag,
    input  wire logic [sac_pkg::RCMP_W-1:0]      n_ways,
    output sac_pkg::lookup_t                     res
);
    import sac_pkg::*;

    always_comb begin
        logic             hit;
        logic             inv_found;
        logic [WAY_W-1:0] hit_way;
        logic [WAY_W-1:0] inv_way;
        logic [WAY_W-1:0] lru_way;
        logic [WAY_W-1:0] target;
        logic [RANK_W-1:0] best;
        logic [RCMP_W-1:0] r;
        logic              in_use;
        row_t              new_row;

        hit       = 1'b0;
        inv_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        lru_way   = '0;
        best      = '0;
        for (int w = 0; w < WAYS; w++) begin
            in_use = (w < int'(n_ways));
            if (!hit && in_use && valid[w] && row[w].tag == tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!inv_found && in_use && !valid[w]) begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
            if (in_use && (w == 0 || row[w].rank > best)) begin
                best    = row[w].rank;
                lru_way = WAY_W'(w);
            end
        end

        target = hit ? hit_way : (inv_found ? inv_way : lru_way);
        r = valid[target] ? RCMP_W'(row[target].rank) : RCMP_W'(WAYS);

        // Valid lines more recent than the touched one move down by one rank.
        new_row = row;
        for (int k = 0; k < WAYS; k++) begin
            if (WAY_W'(k) != target && valid[k] && RCMP_W'(row[k].rank) < r) begin
                new_row[k].rank = row[k].rank + 1'b1;
            end
        end
        new_row[target].rank = '0;
        new_row[target].tag  = tag;

        res.hit      = hit;
        res.eviction = !hit && !inv_found;
        res.way      = target;
        res.row      = new_row;
    end

endmodule

`default_nettype wire

// File: hdl/set_assoc_cache_lru_model_top.sv
// Set-associative cache model with least-recently-used replacement. Each request
// on the input carries a byte address (tdata) and a modify flag (tuser); a load or
// store gives one result, a modify gives two, the second always a hit, and tlast
// marks the final result of a request. An accepted request waits in the lookup
// stage until the output register is free for its first result; one request can
// be accepted every cycle while results are taken, and a modify holds the output
// register for both results. The rate is set by the single output register and the
// one read and one write port of the tag and rank memory; a request accepted while
// its set is written takes the forwarded row. Valid bits are flip-flops cleared by
// reset, so the block is ready right after reset with no clearing pass.
// Configuration (block bits, set bits, ways in use) may be written only while idle.
`default_nettype none

module set_assoc_cache_lru_model_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [sac_pkg::IN_DATA_W-1:0]     s_tdata,   // address
    input  wire logic                              s_tuser,   // is_modify
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [sac_pkg::OUT_DATA_W-1:0]    m_tdata,   // hit_total, miss_total,
                                                              // eviction_total
    output logic      [1:0]                        m_tuser,   // hit, eviction
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sac_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sac_pkg::*;

    logic [BLOCK_W-1:0] cfg_block_reg;
    logic [SETB_W-1:0]  cfg_set_reg;
    logic [NWAYS_W-1:0] cfg_ways_reg;

    logic                 st_valid_reg;
    logic                 st_modify_reg;
    logic                 st_fwd_reg;
    logic [SET_W-1:0]     st_set_reg;
    logic [ADDR_BITS-1:0] st_tag_reg;

    logic [NSETS-1:0][WAYS-1:0] line_valid_reg;
    row_t                       fwd_row_reg;

    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] ev_cnt_reg;

    logic             m_valid_reg;
    logic             m_hit_reg;
    logic             m_ev_reg;
    logic             m_last_reg;
    logic             second_reg;
    logic [CNT_W-1:0] m_hit_tot_reg;
    logic [CNT_W-1:0] m_miss_tot_reg;
    logic [CNT_W-1:0] m_ev_tot_reg;
    logic [CNT_W-1:0] second_hit_reg;

    logic                 accept;
    logic                 fire;
    logic                 out_free;
    logic [ADDR_BITS-1:0] in_addr;
    logic [SETB_W-1:0]    s_eff;
    logic [5:0]           tag_shift;
    logic [ADDR_BITS-1:0] in_shifted;
    logic [SET_W-1:0]     in_set;
    logic [ADDR_BITS-1:0] in_tag;
    logic [RCMP_W-1:0]    n_ways;
    logic [ROW_W-1:0]     ram_rd_data;
    row_t                 cur_row;
    lookup_t              res;
    logic [CNT_W-1:0]     hit_next;
    logic [CNT_W-1:0]     hit2_next;
    logic [CNT_W-1:0]     miss_next;
    logic [CNT_W-1:0]     ev_next;

    // Address split under the current configuration.
    assign in_addr    = s_tdata[ADDR_BITS-1:0];
    assign s_eff      = (int'(cfg_set_reg) > MAX_SET_BITS) ? SETB_W'(MAX_SET_BITS)
                                                           : cfg_set_reg;
    assign tag_shift  = 6'(cfg_block_reg) + 6'(s_eff);
    assign in_shifted = in_addr >> cfg_block_reg;
    assign in_set     = in_shifted[SET_W-1:0] & SET_W'((1 << s_eff) - 1);
    assign in_tag     = in_addr >> tag_shift;

    assign n_ways = (cfg_ways_reg == '0) ? RCMP_W'(1) :
                    (int'(cfg_ways_reg) > WAYS) ? RCMP_W'(WAYS) : RCMP_W'(cfg_ways_reg);

    assign out_free = !m_valid_reg || (m_tready && !second_reg);
    assign fire     = st_valid_reg && out_free;
    assign s_tready = !st_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NSETS)
    ) u_ram (
        .clk     (aclk),
        .wr_en   (fire),
        .wr_addr (st_set_reg),
        .wr_data (res.row),
        .rd_en   (accept),
        .rd_addr (in_set),
        .rd_data (ram_rd_data)
    );

    assign cur_row = st_fwd_reg ? fwd_row_reg : row_t'(ram_rd_data);

    sac_lookup u_lookup (
        .row    (cur_row),
        .valid  (line_valid_reg[st_set_reg]),
        .tag    (st_tag_reg),
        .n_ways (n_ways),
        .res    (res)
    );

    assign hit_next  = res.hit ? sat_inc(hit_cnt_reg) : hit_cnt_reg;
    assign hit2_next = st_modify_reg ? sat_inc(hit_next) : hit_next;
    assign miss_next = res.hit ? miss_cnt_reg : sat_inc(miss_cnt_reg);
    assign ev_next   = res.eviction ? sat_inc(ev_cnt_reg) : ev_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_block_reg  <= BLOCK_BITS_RESET;
            cfg_set_reg    <= SET_BITS_RESET;
            cfg_ways_reg   <= WAYS_USED_RESET;
            st_valid_reg   <= 1'b0;
            st_fwd_reg     <= 1'b0;
            line_valid_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            ev_cnt_reg     <= '0;
            m_valid_reg    <= 1'b0;
            second_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BLOCK_BITS: cfg_block_reg <= cfg_data[BLOCK_W-1:0];
                    CFG_SET_BITS:   cfg_set_reg   <= cfg_data[SETB_W-1:0];
                    CFG_WAYS_USED:  cfg_ways_reg  <= cfg_data[NWAYS_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                st_valid_reg <= 1'b1;
                st_fwd_reg   <= fire && (st_set_reg == in_set);
            end else if (fire) begin
                st_valid_reg <= 1'b0;
            end

            if (fire) begin
                line_valid_reg[st_set_reg][res.way] <= 1'b1;
                hit_cnt_reg  <= hit2_next;
                miss_cnt_reg <= miss_next;
                ev_cnt_reg   <= ev_next;
                m_valid_reg  <= 1'b1;
                second_reg   <= st_modify_reg;
            end else if (m_valid_reg && m_tready) begin
                if (second_reg) begin
                    second_reg <= 1'b0;
                end else begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_modify_reg <= s_tuser;
            st_set_reg    <= in_set;
            st_tag_reg    <= in_tag;
        end
        if (fire) begin
            fwd_row_reg    <= res.row;
            m_hit_reg      <= res.hit;
            m_ev_reg       <= res.eviction;
            m_last_reg     <= !st_modify_reg;
            m_hit_tot_reg  <= hit_next;
            m_miss_tot_reg <= miss_next;
            m_ev_tot_reg   <= ev_next;
            second_hit_reg <= hit2_next;
        end else if (m_valid_reg && m_tready && second_reg) begin
            // The second access of a modify finds the line it just filled or touched.
            m_hit_reg     <= 1'b1;
            m_ev_reg      <= 1'b0;
            m_last_reg    <= 1'b1;
            m_hit_tot_reg <= second_hit_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_ev_tot_reg, m_miss_tot_reg, m_hit_tot_reg};
    assign m_tuser  = {m_ev_reg, m_hit_reg};
    assign m_tlast  = m_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> m_valid_reg && !m_last_reg)
        else $error("pending second result without a first result in the output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_hit_reg && m_ev_reg))
        else $error("result reports both a hit and an eviction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !st_valid_reg |-> s_tready)
        else $error("input stalled while the lookup stage is empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tready && second_reg) |=> (m_valid_reg && m_last_reg && m_hit_reg))
        else $error("second result of a modify is not a final hit");

endmodule

`default_nettype wire

// File: verif/set_assoc_cache_lru_model_top_test.sv
`timescale 1ns / 1ps

module set_assoc_cache_lru_model_top_test;
    import sac_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASE_COUNT     = 12;
    localparam int PHASE_REQUESTS  = 128;

    typedef struct {
        logic [ADDR_BITS-1:0] addr;
        logic                 modify;
    } request_t;

    typedef struct {
        logic        hit;
        logic        eviction;
        logic        last;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } access_result_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [1:0]              m_tuser;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    set_assoc_cache_lru_model_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    request_t        request_queue[$];
    access_result_t  pending_accesses[$];
    int              idle_pct    = 0;
    int              stall_pct   = 0;
    int              error_count = 0;
    int              cycle_count = 0;

    logic [4:0]      block_bits_q = BLOCK_BITS_RESET;
    logic [2:0]      set_bits_q   = SET_BITS_RESET;
    logic [2:0]      ways_used_q  = WAYS_USED_RESET;

    logic [ADDR_BITS-1:0] line_tag_q  [NSETS*WAYS];
    logic                 line_ok_q   [NSETS*WAYS];
    int                   line_rank_q [NSETS*WAYS];

    logic [31:0] hit_total_q      = '0;
    logic [31:0] miss_total_q     = '0;
    logic [31:0] eviction_total_q = '0;

    // Block bits, set bits and ways in use for each random phase.
    int phase_cfg [PHASE_COUNT][3] = '{
        '{4, 4, 4}, '{0, 0, 1}, '{31, 7, 7}, '{0, 6, 4},
        '{16, 6, 0}, '{2, 2, 4}, '{2, 2, 1}, '{2, 2, 4},
        '{5, 3, 2}, '{3, 6, 5}, '{8, 1, 3}, '{4, 7, 4}
    };

    initial begin
        for (int i = 0; i < NSETS * WAYS; i++) begin
            line_tag_q[i]  = '0;
            line_ok_q[i]   = 1'b0;
            line_rank_q[i] = 0;
        end
    end

    function automatic access_result_t cache_lookup(input logic [ADDR_BITS-1:0] addr,
                                                    input logic fin);
        int                   b, s, n, set_idx, base, victim, r, best;
        logic [ADDR_BITS-1:0] tag;
        logic                 hit, found;
        access_result_t       res;
        b = int'(block_bits_q);
        s = int'(set_bits_q);
        n = int'(ways_used_q);
        if (s > MAX_SET_BITS) s = MAX_SET_BITS;
        if (n > WAYS) n = WAYS;
        if (n == 0) n = 1;
        set_idx = int'((addr >> b) & ((48'd1 << s) - 48'd1));
        tag = addr >> (b + s);
        base = set_idx * WAYS;
        hit = 1'b0;
        found = 1'b0;
        victim = 0;
        res.eviction = 1'b0;
        for (int w = 0; w < n; w++) begin
            if (!hit && line_ok_q[base + w] && line_tag_q[base + w] == tag) begin
                hit = 1'b1;
                victim = w;
            end
        end
        if (hit) begin
            if (hit_total_q != '1) hit_total_q++;
        end else begin
            if (miss_total_q != '1) miss_total_q++;
            for (int w = 0; w < n; w++) begin
                if (!found && !line_ok_q[base + w]) begin
                    found = 1'b1;
                    victim = w;
                end
            end
            if (!found) begin
                best = 0;
                for (int w = 0; w < n; w++) begin
                    if (w == 0 || line_rank_q[base + w] > best) begin
                        best = line_rank_q[base + w];
                        victim = w;
                    end
                end
                res.eviction = 1'b1;
                if (eviction_total_q != '1) eviction_total_q++;
            end
        end
        // The line used moves to the front; valid lines ahead of it shift back by one.
        r = line_ok_q[base + victim] ? line_rank_q[base + victim] : WAYS;
        for (int k = 0; k < WAYS; k++) begin
            if (k != victim && line_ok_q[base + k] && line_rank_q[base + k] < r)
                line_rank_q[base + k]++;
        end
        line_rank_q[base + victim] = 0;
        line_ok_q[base + victim]   = 1'b1;
        line_tag_q[base + victim]  = tag;
        res.hit            = hit;
        res.last           = fin;
        res.hit_total      = hit_total_q;
        res.miss_total     = miss_total_q;
        res.eviction_total = eviction_total_q;
        return res;
    endfunction

    function automatic void queue_request(input logic [ADDR_BITS-1:0] addr,
                                          input logic modify);
        request_t req;
        req.addr   = addr;
        req.modify = modify;
        request_queue.push_back(req);
    endfunction

    function automatic logic [ADDR_BITS-1:0] random_address();
        int          b, s;
        logic [63:0] tag, set_idx, offset, addr;
        b = int'(block_bits_q);
        s = int'(set_bits_q);
        if (s > MAX_SET_BITS) s = MAX_SET_BITS;
        if ($urandom_range(99) < 10) begin
            addr = {$urandom, $urandom};
        end else begin
            tag = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(5));
            set_idx = ($urandom_range(3) == 0) ? 64'($urandom) : 64'($urandom_range(3));
            set_idx = set_idx & ((64'd1 << s) - 64'd1);
            offset = {$urandom, $urandom} & ((64'd1 << b) - 64'd1);
            addr = (tag << (b + s)) | (set_idx << b) | offset;
        end
        return addr[ADDR_BITS-1:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_BLOCK_BITS: block_bits_q = value;
            CFG_SET_BITS:   set_bits_q   = value[2:0];
            CFG_WAYS_USED:  ways_used_q  = value[2:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (request_queue.size() != 0 || pending_accesses.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin : drive_requests
        request_t req;
        logic     send;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            s_tvalid <= 1'b1;
        end else begin
            if (s_tvalid) begin
                req = request_queue.pop_front();
                if (req.modify) pending_accesses.push_back(cache_lookup(req.addr, 1'b0));
                pending_accesses.push_back(cache_lookup(req.addr, 1'b1));
            end
            send = request_queue.size() != 0 && $urandom_range(99) >= idle_pct;
            s_tvalid <= send;
            if (send) begin
                s_tdata <= request_queue[0].addr;
                s_tuser <= request_queue[0].modify;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        access_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_accesses.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got hit=%0b eviction=%0b",
                             $time, m_tuser[0], m_tuser[1]);
                    error_count++;
                end else begin
                    want = pending_accesses.pop_front();
                    check_field("hit", 32'(want.hit), 32'(m_tuser[0]));
                    check_field("eviction", 32'(want.eviction), 32'(m_tuser[1]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                    check_field("hit_total", want.hit_total, m_tdata[31:0]);
                    check_field("miss_total", want.miss_total, m_tdata[63:32]);
                    check_field("eviction_total", want.eviction_total, m_tdata[95:64]);
                end
            end
            m_tready <= $urandom_range(99) >= stall_pct;
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("set_assoc_cache_lru_model_top_test: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: one way, sixteen sets, sixteen-byte lines.
        queue_request(48'h0000_0000_0000, 1'b0);
        queue_request(48'h0000_0000_0000, 1'b0);
        queue_request(48'hFFFF_FFFF_FFFF, 1'b0);
        queue_request(48'h0000_0000_000F, 1'b0);
        queue_request(48'h0000_0000_0100, 1'b0);
        queue_request(48'h0000_0000_0000, 1'b1);
        queue_request(48'h0000_0000_0010, 1'b1);
        queue_request(48'h0000_0000_0010, 1'b1);
        queue_request(48'h8000_0000_0000, 1'b0);
        queue_request(48'h7FFF_FFFF_FFF0, 1'b0);
        queue_request(48'hAAAA_AAAA_AAAA, 1'b1);
        queue_request(48'h5555_5555_5555, 1'b0);
        queue_request(48'hFFFF_FFFF_FFFF, 1'b1);
        queue_request(48'h0000_0000_00F0, 1'b0);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_reg(CFG_BLOCK_BITS, CFG_DATA_W'(phase_cfg[p][0]));
            write_reg(CFG_SET_BITS, CFG_DATA_W'(phase_cfg[p][1]));
            write_reg(CFG_WAYS_USED, CFG_DATA_W'(phase_cfg[p][2]));
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            for (int i = 0; i < PHASE_REQUESTS; i++)
                queue_request(random_address(), $urandom_range(3) == 0);
            wait_drained();
        end

        repeat (16) @(posedge aclk);
        if (error_count == 0 && pending_accesses.size() == 0) begin
            $display("set_assoc_cache_lru_model_top_test: PASS");
        end else begin
            $display("set_assoc_cache_lru_model_top_test: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/sac_pkg.sv
hdl/sac_ram.sv
hdl/sac_lookup.sv
hdl/set_assoc_cache_lru_model_top.sv
verif/set_assoc_cache_lru_model_top_test.sv
